FILE: hdl/lad_pkg.sv
// Shared types and constants for the linear array deque.
`default_nettype none

package lad_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic signed [DATA_W-1:0] t_word;

    // Slot array controls from the index logic.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

FILE: hdl/lad_if.sv
// Request and result channel interfaces for the linear array deque.
`default_nettype none

interface lad_cmd_if;
    logic          valid;
    logic          ready;
    lad_pkg::t_cmd cmd;
    lad_pkg::t_word push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface lad_res_if;
    logic             valid;
    logic             ready;
    lad_pkg::t_status status;
    lad_pkg::t_word   pop_value;

    modport source (output valid, output status, output pop_value, input ready);
    modport sink   (input valid, input status, input pop_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/lad_mem.sv
// Slot storage: one write port, one registered read port.
`default_nettype none

module lad_mem #(
    parameter int DEPTH = lad_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire lad_pkg::t_mem_ctl i_ctl,
    input  wire logic [IW-1:0]     i_waddr,
    input  wire lad_pkg::t_word    i_wdata,
    input  wire logic [IW-1:0]     i_raddr,
    output      lad_pkg::t_word    o_rdata
);

    lad_pkg::t_word r_slots [DEPTH];
    lad_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_slots[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_slots[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/lad_ctrl.sv
// Front/back index registers and per-request decision logic.
`default_nettype none

module lad_ctrl #(
    parameter int DEPTH = lad_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire lad_pkg::t_cmd     i_cmd,
    output      lad_pkg::t_mem_ctl o_ctl,
    output      logic [IW-1:0]     o_waddr,
    output      logic [IW-1:0]     o_raddr,
    output      lad_pkg::t_status  o_status,
    output      logic              o_pop_ok
);

    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic          single;

    assign single = (r_head == r_tail);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        o_ctl     = '0;
        o_waddr   = '0;
        o_raddr   = r_head;
        o_status  = lad_pkg::ST_DONE;
        o_pop_ok  = 1'b0;
        unique case (i_cmd)
            lad_pkg::CMD_PUSH_FRONT: begin
                if (r_empty) begin
                    n_head      = '0;
                    n_tail      = '0;
                    n_empty     = 1'b0;
                    o_ctl.wr_en = 1'b1;
                end else if (r_head == '0) begin
                    o_status = lad_pkg::ST_FULL;
                end else begin
                    n_head      = r_head - IW'(1);
                    o_waddr     = n_head;
                    o_ctl.wr_en = 1'b1;
                end
            end
            lad_pkg::CMD_PUSH_BACK: begin
                if (r_empty) begin
                    n_head      = '0;
                    n_tail      = '0;
                    n_empty     = 1'b0;
                    o_ctl.wr_en = 1'b1;
                end else if (r_tail == LAST_SLOT) begin
                    o_status = lad_pkg::ST_FULL;
                end else begin
                    n_tail      = r_tail + IW'(1);
                    o_waddr     = n_tail;
                    o_ctl.wr_en = 1'b1;
                end
            end
            lad_pkg::CMD_POP_FRONT: begin
                if (r_empty) begin
                    o_status = lad_pkg::ST_EMPTY;
                end else begin
                    o_raddr     = r_head;
                    o_ctl.rd_en = 1'b1;
                    o_pop_ok    = 1'b1;
                    if (single) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_head = r_head + IW'(1);
                    end
                end
            end
            lad_pkg::CMD_POP_BACK: begin
                if (r_empty) begin
                    o_status = lad_pkg::ST_EMPTY;
                end else begin
                    o_raddr     = r_tail;
                    o_ctl.rd_en = 1'b1;
                    o_pop_ok    = 1'b1;
                    if (single) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_tail = r_tail - IW'(1);
                    end
                end
            end
        endcase
        // drop every effect when no request is taken
        if (!i_accept) begin
            n_head  = r_head;
            n_tail  = r_tail;
            n_empty = r_empty;
            o_ctl   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/linear_array_deque.sv
// Top level of the linear array deque: request intake, result register, checks.
//
// A double-ended queue of DEPTH signed 32-bit words in a fixed, non-wrapping
// array. Each request (push front, push back, pop front, pop back) produces
// exactly one result: a status (done, empty on pop, no room at that end) and
// the popped word, which is zero for pushes and refused pops. A request is
// taken every cycle while the result side keeps up; its result appears in the
// next cycle from the result register, and the popped word comes from the
// registered read port of the slot array. The front can only grow toward
// slot 0 and the back only toward slot DEPTH-1, so pushes are refused at
// those ends even when the other end has room; a push into an empty deque
// always lands in slot 0. No clearing pass follows reset.
`default_nettype none

module linear_array_deque #(
    parameter int DEPTH = lad_pkg::DEPTH_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lad_cmd_if.sink    i_cmd,
    lad_res_if.source  o_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              accept;
    lad_pkg::t_mem_ctl mem_ctl;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    lad_pkg::t_status  status;
    logic              pop_ok;
    lad_pkg::t_word    rdata;

    logic              r_out_valid;
    lad_pkg::t_status  r_status;
    logic              r_pop_ok;

    // take a request whenever the result register is free or being drained
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    lad_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd.cmd),
        .o_ctl    (mem_ctl),
        .o_waddr  (waddr),
        .o_raddr  (raddr),
        .o_status (status),
        .o_pop_ok (pop_ok)
    );

    lad_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (i_cmd.push_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
            r_pop_ok <= pop_ok;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_status;
    assign o_res.pop_value = r_pop_ok ? rdata : '0;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_res.valid)
        else $error("accepted request produced no result");

    a_zero_on_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != lad_pkg::ST_DONE) |-> (o_res.pop_value == '0))
        else $error("refused request returned a nonzero word");

    a_push_never_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.cmd == lad_pkg::CMD_PUSH_FRONT ||
                    i_cmd.cmd == lad_pkg::CMD_PUSH_BACK))
        |=> (o_res.status != lad_pkg::ST_EMPTY))
        else $error("push reported empty status");

    a_pop_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.cmd == lad_pkg::CMD_POP_FRONT ||
                    i_cmd.cmd == lad_pkg::CMD_POP_BACK)) |-> !mem_ctl.wr_en)
        else $error("pop request wrote the slot array");

endmodule

`default_nettype wire
